FILE: hdl/htfd_pkg.sv
// Shared types, constants and the CRC-8 step for the humidity/temperature frame decoder.
// No dependencies.
package htfd_pkg;

  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [7:0]  CRC_POLY  = 8'h31;

  // Byte slots of the six-byte reply
  localparam logic [2:0]  POS_T_MSB = 3'd0;
  localparam logic [2:0]  POS_T_LSB = 3'd1;
  localparam logic [2:0]  POS_T_CRC = 3'd2;
  localparam logic [2:0]  POS_H_MSB = 3'd3;
  localparam logic [2:0]  POS_H_LSB = 3'd4;
  localparam logic [2:0]  POS_H_CRC = 3'd5;

  // Conversion constants, results in hundredths
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [15:0] FULL_SCALE  = 16'd65535;
  localparam logic [16:0] TEMP_OFFSET = 17'd4500;
  localparam logic [15:0] HUM_OFFSET  = 16'd600;
  localparam logic [15:0] HUM_MAX     = 16'd10000;

  // One complete frame handed from front to back
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_ok;
    logic        hum_ok;
  } htfd_job_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/htfd_front.sv
// Front end: takes reply bytes, tracks the byte slot, runs the CRC and assembles words.
// Depends on htfd_pkg.
module htfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  output logic                push_o,
  output htfd_pkg::htfd_job_t job_o
);
  import htfd_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] tword_q, tword_d;
  logic [7:0]  hhi_q, hhi_d;
  logic [7:0]  hlo_q, hlo_d;
  logic        tok_q, tok_d;

  // frame_start realigns; a slot beyond the last is taken as the first
  assign pos = (frame_start_i || pos_q > POS_H_CRC) ? POS_T_MSB : pos_q;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    tword_d = tword_q;
    hhi_d   = hhi_q;
    hlo_d   = hlo_q;
    tok_d   = tok_q;
    push_o  = 1'b0;
    job_o.temp_word = tword_q;
    job_o.hum_word  = {hhi_q, hlo_q};
    job_o.temp_ok   = tok_q;
    job_o.hum_ok    = (crc_q == rx_byte_i);
    if (beat_i) begin
      pos_d = pos + 3'd1;
      unique case (pos)
        POS_T_LSB: begin
          crc_d   = crc8_byte(crc_q, rx_byte_i);
          tword_d = {tword_q[15:8], rx_byte_i};
        end
        POS_T_CRC: begin
          tok_d = (crc_q == rx_byte_i);
          crc_d = CRC_INIT;
        end
        POS_H_MSB: begin
          crc_d = crc8_byte(crc_q, rx_byte_i);
          hhi_d = rx_byte_i;
        end
        POS_H_LSB: begin
          crc_d = crc8_byte(crc_q, rx_byte_i);
          hlo_d = rx_byte_i;
        end
        POS_H_CRC: begin
          push_o = 1'b1;
          crc_d  = CRC_INIT;
          pos_d  = POS_T_MSB;
        end
        default: begin
          crc_d   = crc8_byte(CRC_INIT, rx_byte_i);
          tword_d = {rx_byte_i, 8'h00};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_T_MSB;
      crc_q   <= CRC_INIT;
      tword_q <= '0;
      hhi_q   <= '0;
      hlo_q   <= '0;
      tok_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tword_q <= tword_d;
      hhi_q   <= hhi_d;
      hlo_q   <= hlo_d;
      tok_q   <= tok_d;
    end
  end

endmodule

FILE: hdl/htfd_queue.sv
// Short frame queue between front and back end.
// Depends on htfd_pkg.
module htfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  htfd_pkg::htfd_job_t push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output htfd_pkg::htfd_job_t head_o
);
  import htfd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  htfd_job_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/htfd_back.sv
// Back end: scales both words to hundredths in two stages, ending in the output register.
// Depends on htfd_pkg.
module htfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  htfd_pkg::htfd_job_t job_i,
  output logic                job_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [14:0]  temperature_centi_o,
  output logic [13:0]         humidity_centi_o,
  output logic                temp_crc_ok_o,
  output logic                hum_crc_ok_o,
  output logic                reading_valid_o
);
  import htfd_pkg::*;

  // floor(x / 65535) for x < 65535 * 2^15: x = a*65536 + b = a*65535 + (a + b)
  function automatic logic [15:0] div_full_scale(input logic [30:0] x);
    logic [16:0] s;
    s = {2'b00, x[30:16]} + {1'b0, x[15:0]};
    return {1'b0, x[30:16]} + ((s >= {1'b0, FULL_SCALE}) ? 16'd1 : 16'd0);
  endfunction

  logic        v1_q, v2_q, adv1, adv2;
  logic [30:0] tprod_q;
  logic [29:0] hprod_q;
  logic        tok1_q, hok1_q;
  logic [15:0] tq, hq, hsub;
  logic [16:0] tsum;
  logic signed [14:0] temp_d;
  logic [13:0] hum_d;
  logic        valid1;

  assign adv2       = !v2_q || !out_stall_i;
  assign adv1       = !v1_q || adv2;
  assign job_take_o = job_valid_i && adv1;
  assign out_valid_o = v2_q;

  assign valid1 = tok1_q && hok1_q;
  assign tq     = div_full_scale(tprod_q);
  assign hq     = div_full_scale({1'b0, hprod_q});
  assign tsum   = {1'b0, tq} - TEMP_OFFSET;
  assign hsub   = hq - HUM_OFFSET;

  always_comb begin
    temp_d = '0;
    hum_d  = '0;
    if (valid1) begin
      temp_d = signed'(tsum[14:0]);
      if (hq < HUM_OFFSET) begin
        hum_d = '0;
      end else if (hsub > HUM_MAX) begin
        hum_d = HUM_MAX[13:0];
      end else begin
        hum_d = hsub[13:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && job_valid_i) begin
      tprod_q <= {15'd0, job_i.temp_word} * {16'd0, TEMP_SCALE};
      hprod_q <= {14'd0, job_i.hum_word} * {16'd0, HUM_SCALE};
      tok1_q  <= job_i.temp_ok;
      hok1_q  <= job_i.hum_ok;
    end
    if (adv2 && v1_q) begin
      temperature_centi_o <= temp_d;
      humidity_centi_o    <= hum_d;
      temp_crc_ok_o       <= tok1_q;
      hum_crc_ok_o        <= hok1_q;
      reading_valid_o     <= valid1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= job_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

endmodule

FILE: hdl/humidity_temp_frame_decoder_top.sv
// Top level of the humidity/temperature frame decoder: front end, frame queue, back end.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | rx_byte_i, frame_start_i
//   out     | source    | out_valid_o/out_stall_i | temperature_centi_o, humidity_centi_o,
//           |           |                      | temp_crc_ok_o, hum_crc_ok_o, reading_valid_o
//
// One byte beat per cycle while in_stall_o is low; the CRC step is one unrolled byte-wide
// update in the front end. The edge that takes the sixth byte enters the frame in the queue;
// it then passes through the multiply stage and the output register (scaling by 65535 done
// as a fold and one correction compare).
// Reset clears the byte slot, the CRC to its seed, the queue and all stage valids.
// in_stall_o is high only while the frame queue is full; the back end stalls on out_stall_i
// without holding the front end until the queue fills.
module humidity_temp_frame_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic               temp_crc_ok_o,
  output logic               hum_crc_ok_o,
  output logic               reading_valid_o
);
  import htfd_pkg::*;

  logic      beat;       // accepted input byte
  logic      push;       // sixth byte seen, frame complete
  logic      q_full, q_empty, q_pop;
  htfd_job_t job_in, job_head;

  assign beat       = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .job_o         (job_in)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (job_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (job_head)
  );

  htfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (!q_empty),
    .job_i               (job_head),
    .job_take_o          (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .temp_crc_ok_o       (temp_crc_ok_o),
    .hum_crc_ok_o        (hum_crc_ok_o),
    .reading_valid_o     (reading_valid_o)
  );

endmodule
